// File: hw/rtl/top_k_count_tracker_top_assert.svh
// assertion macros for the top-k count tracker
`ifndef TOP_K_COUNT_TRACKER_TOP_ASSERT_SVH
`define TOP_K_COUNT_TRACKER_TOP_ASSERT_SVH

`ifndef SYNTH

// property must hold at every edge out of reset
`define TKCT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen out of reset
`define TKCT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define TKCT_ASSERT(lbl, clk, rstn, prop, msg)
`define TKCT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: hw/rtl/tkct_pkg.sv
`default_nettype none

package tkct_pkg;

    localparam int TOP_ENTRIES = 20;
    localparam int ID_BITS     = 32;
    localparam int SCORE_BITS  = 32;
    localparam int RANK_BITS   = 6;
    localparam int IDX_BITS    = (TOP_ENTRIES > 1) ? $clog2(TOP_ENTRIES) : 1;

    localparam logic OP_OFFER  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the beat, restart scan, clear marks and rank
        logic scan;   // visit one slot
        logic write;  // replace the minimum slot if the offer beats it
        logic emit;   // put out one ranked result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic rank_last;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/tkct_ctrl.sv
`default_nettype none

`include "top_k_count_tracker_top_assert.svh"

module tkct_ctrl
    import tkct_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic op,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_OSCAN  = 3'd1;
    localparam logic [2:0] S_OWRITE = 3'd2;
    localparam logic [2:0] S_RSCAN  = 3'd3;
    localparam logic [2:0] S_REMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op == OP_REPORT) ? S_RSCAN : S_OSCAN;
                end
            end
            S_OSCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_OWRITE;
                end
            end
            S_OWRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_IDLE;
            end
            S_RSCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_REMIT;
                end
            end
            S_REMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = sts.rank_last ? S_IDLE : S_RSCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `TKCT_ASSERT(a_start_goes_busy, clk, rst_n, (start && !busy) |=> busy, "start did not raise busy")
    `TKCT_NEVER(a_one_cmd, clk, rst_n, !$onehot0(cmd), "more than one command at once")

endmodule

`default_nettype wire

// File: hw/rtl/tkct_datapath.sv
`default_nettype none

`include "top_k_count_tracker_top_assert.svh"

module tkct_datapath
    import tkct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic                  op,
    input  wire logic [ID_BITS-1:0]    user_id,
    input  wire logic [SCORE_BITS-1:0] score,
    output sts_t                       sts,
    output logic                       valid,
    output logic [RANK_BITS-1:0]       rank,
    output logic [ID_BITS-1:0]         ranked_id,
    output logic [SCORE_BITS-1:0]      ranked_score,
    output logic                       last
);

    logic [ID_BITS-1:0]    slot_id_reg    [TOP_ENTRIES];
    logic [SCORE_BITS-1:0] slot_score_reg [TOP_ENTRIES];
    logic [TOP_ENTRIES-1:0] marks_reg;

    logic [IDX_BITS-1:0]   idx_reg;
    logic [IDX_BITS-1:0]   rank_reg;
    logic                  found_reg;
    logic                  valid_reg;

    logic                  op_reg;
    logic [ID_BITS-1:0]    in_id_reg;
    logic [SCORE_BITS-1:0] in_score_reg;
    logic [IDX_BITS-1:0]   best_idx_reg;
    logic [ID_BITS-1:0]    best_id_reg;
    logic [SCORE_BITS-1:0] best_score_reg;

    logic [RANK_BITS-1:0]  rank_out_reg;
    logic [ID_BITS-1:0]    id_out_reg;
    logic [SCORE_BITS-1:0] score_out_reg;
    logic                  last_out_reg;

    logic [ID_BITS-1:0]    cur_id;
    logic [SCORE_BITS-1:0] cur_score;
    logic                  take;
    logic                  do_replace;

    assign cur_id    = slot_id_reg[idx_reg];
    assign cur_score = slot_score_reg[idx_reg];

    // report looks for the max among unmarked slots, offer for the min
    always_comb
    begin
        if (op_reg == OP_REPORT)
        begin
            take = !marks_reg[idx_reg] && (!found_reg || (cur_score > best_score_reg));
        end
        else
        begin
            take = !found_reg || (cur_score < best_score_reg);
        end
    end

    assign do_replace    = cmd.write && (in_score_reg > best_score_reg);
    assign sts.scan_last = (idx_reg == IDX_BITS'(TOP_ENTRIES - 1));
    assign sts.rank_last = (rank_reg == IDX_BITS'(TOP_ENTRIES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_ENTRIES; i++)
            begin
                slot_id_reg[i]    <= '0;
                slot_score_reg[i] <= '0;
            end
            marks_reg <= '0;
            idx_reg   <= '0;
            rank_reg  <= '0;
            found_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.load)
            begin
                marks_reg <= '0;
                idx_reg   <= '0;
                rank_reg  <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan)
            begin
                idx_reg <= idx_reg + IDX_BITS'(1);
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (do_replace)
            begin
                slot_id_reg[best_idx_reg]    <= in_id_reg;
                slot_score_reg[best_idx_reg] <= in_score_reg;
            end
            if (cmd.emit)
            begin
                marks_reg[best_idx_reg] <= 1'b1;
                rank_reg                <= rank_reg + IDX_BITS'(1);
                idx_reg                 <= '0;
                found_reg               <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= op;
            in_id_reg    <= user_id;
            in_score_reg <= score;
        end
        if (cmd.scan && take)
        begin
            best_idx_reg   <= idx_reg;
            best_id_reg    <= cur_id;
            best_score_reg <= cur_score;
        end
        if (cmd.emit)
        begin
            rank_out_reg  <= RANK_BITS'(rank_reg);
            id_out_reg    <= best_id_reg;
            score_out_reg <= best_score_reg;
            last_out_reg  <= sts.rank_last;
        end
    end

    assign valid        = valid_reg;
    assign rank         = rank_out_reg;
    assign ranked_id    = id_out_reg;
    assign ranked_score = score_out_reg;
    assign last         = last_out_reg;

    `TKCT_ASSERT(a_emit_fresh, clk, rst_n, cmd.emit |-> (found_reg && !marks_reg[best_idx_reg]), "emit of a used or unfound slot")
    `TKCT_ASSERT(a_last_rank, clk, rst_n, (valid_reg && last_out_reg) |-> (rank_out_reg == RANK_BITS'(TOP_ENTRIES - 1)), "last flag on wrong rank")
    `TKCT_ASSERT(a_write_found, clk, rst_n, cmd.write |-> (found_reg && (op_reg == OP_OFFER)), "write without a minimum slot")

endmodule

`default_nettype wire

// File: hw/rtl/top_k_count_tracker_top.sv
// top-k count tracker: keeps the TOP_ENTRIES records with the highest counts
// command channel: a beat (op, user_id, score) is taken when start is high
// and busy is low; busy stays high until the command has finished
// op 0 offers a record: the slots are scanned one per cycle for the lowest
// count (lowest index on ties), and if the offered score is strictly larger
// that slot takes the offered id and score; no result beat is produced
// an offer keeps busy high through the scan of every slot and the write-back,
// so a new offer is taken only once both have finished
// op 1 asks for a report: TOP_ENTRIES result beats in descending score order,
// equal scores by lower slot index, last set on the final one
// each rank takes a scan of every slot for the largest unreported score, then
// an emit step that marks that slot; the result beat is registered from the
// emit, and the scan for the next rank then starts over from slot 0
// results are shown for one cycle, marked by valid; the receiver cannot stall
// a report leaves the table as it is
// reset (rst_n low, asynchronous) clears every slot to id 0, score 0
`default_nettype none

module top_k_count_tracker_top
    import tkct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  op,
    input  wire logic [ID_BITS-1:0]    user_id,
    input  wire logic [SCORE_BITS-1:0] score,
    // result channel
    output logic                       valid,
    output logic [RANK_BITS-1:0]       rank,
    output logic [ID_BITS-1:0]         ranked_id,
    output logic [SCORE_BITS-1:0]      ranked_score,
    output logic                       last
);

    // command and status between sequencer and slot datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: idle, scan, write back or emit
    tkct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // slot table, scan compare, report marks and result registers
    tkct_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (op),
        .user_id      (user_id),
        .score        (score),
        .sts          (sts),
        .valid        (valid),
        .rank         (rank),
        .ranked_id    (ranked_id),
        .ranked_score (ranked_score),
        .last         (last)
    );

endmodule

`default_nettype wire
